>>> rtl/yay0_pkg.sv
// Shared types and constants for the Yay0 LZ decompressor.
// Used by yay0_ring, yay0_packer and yay0_lz_decompressor; no dependencies.
`timescale 1ns / 1ps

package yay0_pkg;

  localparam int WINDOW_BYTES         = 4096;
  localparam int RING_AW              = $clog2(WINDOW_BYTES);
  localparam int COUNT_W              = 25;
  localparam int SIZE_W               = 24;
  localparam int LEN_W                = 9;
  localparam int CODE_SHIFT           = 12;
  localparam int BYTES_PER_RESULT_DEF = 8;
  localparam int CFG_AW               = 3;

  localparam logic [LEN_W-1:0]  LONG_BIAS  = 9'd18;
  localparam logic [LEN_W-1:0]  SHORT_BIAS = 9'd2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 24'd1;

  // Register index as decoded from paddr[2].
  localparam logic REG_DECODED_SIZE = 1'b0;

  typedef struct packed {
    logic        is_literal;
    logic [7:0]  literal_byte;
    logic [15:0] link_word;
    logic [7:0]  extra_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        token_last;
    logic        done_res;
  } out_item_t;

  // One decoded byte handed from the control logic to the packer.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
    logic       done;
  } pack_req_t;

endpackage

>>> rtl/yay0_lz_decompressor.sv
// Yay0 LZ decompressor back end. Literal tokens can follow back to back; a
// copy token of length L (3 to 273 bytes) yields one byte per cycle while
// the packer takes bytes, set by the single read port of the 4096-byte history
// ring (registered read data, the previous byte forwarded when the
// distance is one). The ring needs no clearing pass after reset: a fill count
// makes reads from before the first decoded byte return zero. Results carry up
// to BYTES_PER_RESULT bytes; tokens arriving after done are taken and dropped.
// Depends on yay0_pkg, yay0_ring and yay0_packer.
`timescale 1ns / 1ps

module yay0_lz_decompressor import yay0_pkg::*; #(
  parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic               state_r, state_nxt;
  logic [COUNT_W-1:0] pc_r, pc_nxt;
  logic [COUNT_W-1:0] iss_pc_r, iss_pc_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [RING_AW-1:0] dm1_r, dm1_nxt;
  logic               full_r, full_nxt;
  logic               finished_r, finished_nxt;
  logic [7:0]         wbyte_r, wbyte_nxt;
  logic [SIZE_W-1:0]  size_r;

  logic               s2_valid_r, s2_valid_nxt;
  logic               s2_lit_r, s2_lit_nxt;
  logic [7:0]         s2_byte_r, s2_byte_nxt;
  logic               s2_zero_r, s2_zero_nxt;
  logic               s2_fwd_r, s2_fwd_nxt;
  logic               s2_last_r, s2_last_nxt;

  logic               pk_take;
  pack_req_t          pk_req;
  logic               resolve;
  logic               issue;
  logic               accept;
  logic               fin_eff;
  logic [7:0]         byte_val;
  logic [COUNT_W-1:0] pc_inc;
  logic               done_now;
  logic [RING_AW-1:0] raddr;
  logic [7:0]         ring_rdata;
  logic [3:0]         len_code;
  logic [LEN_W-1:0]   copy_len;
  logic               cfg_wr;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_DECODED_SIZE) ? {8'd0, size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_DECODED_SIZE)) begin
      size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  // Byte resolution stage: the ring data of the most recently issued read.
  assign resolve  = s2_valid_r && pk_take;
  assign byte_val = s2_lit_r  ? s2_byte_r :
                    s2_zero_r ? 8'd0      :
                    s2_fwd_r  ? wbyte_r   : ring_rdata;
  assign pc_inc   = pc_r + 25'd1;
  assign done_now = pc_inc >= {1'b0, size_r};
  assign fin_eff  = finished_r || (resolve && s2_last_r && done_now);

  assign pk_req.vld  = s2_valid_r;
  assign pk_req.data = byte_val;
  assign pk_req.last = s2_last_r;
  assign pk_req.done = done_now;

  assign in_ready = (state_r == ST_IDLE) && (!s2_valid_r || pk_take);
  assign accept   = in_valid && in_ready;
  assign issue    = (state_r == ST_COPY) && (!s2_valid_r || pk_take);
  assign raddr    = iss_pc_r[RING_AW-1:0] - dm1_r - 12'd1;

  assign len_code = in_data.link_word[15:CODE_SHIFT];
  assign copy_len = (len_code == 4'd0) ? ({1'b0, in_data.extra_count} + LONG_BIAS)
                                       : ({5'd0, len_code} + SHORT_BIAS);

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = resolve ? pc_inc : pc_r;
    iss_pc_nxt   = iss_pc_r;
    rem_nxt      = rem_r;
    dm1_nxt      = dm1_r;
    full_nxt     = full_r || (|pc_r[COUNT_W-1:RING_AW]);
    finished_nxt = fin_eff;
    wbyte_nxt    = resolve ? byte_val : wbyte_r;
    s2_valid_nxt = s2_valid_r && !resolve;
    s2_lit_nxt   = s2_lit_r;
    s2_byte_nxt  = s2_byte_r;
    s2_zero_nxt  = s2_zero_r;
    s2_fwd_nxt   = s2_fwd_r;
    s2_last_nxt  = s2_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && !fin_eff) begin
          if (in_data.is_literal) begin
            s2_valid_nxt = 1'b1;
            s2_lit_nxt   = 1'b1;
            s2_byte_nxt  = in_data.literal_byte;
            s2_last_nxt  = 1'b1;
          end else begin
            state_nxt  = ST_COPY;
            iss_pc_nxt = pc_nxt;
            rem_nxt    = copy_len;
            dm1_nxt    = in_data.link_word[RING_AW-1:0];
          end
        end
      end
      ST_COPY: begin
        if (issue) begin
          s2_valid_nxt = 1'b1;
          s2_lit_nxt   = 1'b0;
          // Before the ring has filled, sources ahead of the fill point read zero.
          s2_zero_nxt  = !full_r && (iss_pc_r[COUNT_W-1:RING_AW] == '0) &&
                         (iss_pc_r[RING_AW-1:0] <= dm1_r);
          // At distance one the source is written in the same cycle as it is read.
          s2_fwd_nxt   = (dm1_r == '0);
          s2_last_nxt  = (rem_r == 9'd1);
          iss_pc_nxt   = iss_pc_r + 25'd1;
          rem_nxt      = rem_r - 9'd1;
          if (rem_r == 9'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pc_r       <= '0;
      full_r     <= 1'b0;
      finished_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pc_r       <= pc_nxt;
      full_r     <= full_nxt;
      finished_r <= finished_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_pc_r  <= iss_pc_nxt;
    rem_r     <= rem_nxt;
    dm1_r     <= dm1_nxt;
    wbyte_r   <= wbyte_nxt;
    s2_lit_r  <= s2_lit_nxt;
    s2_byte_r <= s2_byte_nxt;
    s2_zero_r <= s2_zero_nxt;
    s2_fwd_r  <= s2_fwd_nxt;
    s2_last_r <= s2_last_nxt;
  end

  yay0_ring u_ring (
    .clk   (clk),
    .we    (resolve),
    .waddr (pc_r[RING_AW-1:0]),
    .wdata (byte_val),
    .re    (issue),
    .raddr (raddr),
    .rdata (ring_rdata)
  );

  yay0_packer #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .pk_req    (pk_req),
    .pk_take   (pk_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A byte waiting on a full output register must not be lost.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !pk_take |=> s2_valid_r)
    else $error("stalled byte dropped");

  // No new request is taken while a copy is still issuing reads.
  a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COPY |-> !in_ready)
    else $error("request accepted during copy");

  // Each resolved byte advances the fill count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    resolve |=> pc_r == $past(pc_inc))
    else $error("fill count out of step");

  // Once done, decoding stays done.
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("done flag cleared");

endmodule

>>> rtl/yay0_ring.sv
// History ring: 4096 x 8 synchronous memory, one write and one read port.
// Read data is registered and holds while no read is issued. Uses yay0_pkg.
`timescale 1ns / 1ps

module yay0_ring import yay0_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [RING_AW-1:0] waddr,
  input  logic [7:0]         wdata,
  input  logic               re,
  input  logic [RING_AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [WINDOW_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/yay0_packer.sv
// Output packer: gathers decoded bytes into results of up to BYTES_PER_RESULT
// bytes and holds each finished result in the output register. Uses yay0_pkg.
`timescale 1ns / 1ps

module yay0_packer import yay0_pkg::*; #(
  parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pack_req_t pk_req,
  output logic      pk_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [63:0] pack_val_r;
  logic [3:0]  pack_cnt_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [3:0]  cnt_inc;
  logic        flush;
  logic        out_free;
  logic [63:0] merged;

  assign cnt_inc  = pack_cnt_r + 4'd1;
  assign flush    = pk_req.vld && ((cnt_inc == 4'(BYTES_PER_RESULT)) || pk_req.last);
  assign out_free = !out_valid_r || out_ready;
  // A byte that closes a result can only go when the output register frees up.
  assign pk_take  = !flush || out_free;
  assign merged   = pack_val_r | ({56'd0, pk_req.data} << {pack_cnt_r[2:0], 3'b000});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_val_r  <= '0;
      pack_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pk_req.vld && pk_take) begin
        if (flush) begin
          out_valid_r <= 1'b1;
          pack_val_r  <= '0;
          pack_cnt_r  <= '0;
        end else begin
          pack_val_r <= merged;
          pack_cnt_r <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pk_req.vld && pk_take && flush) begin
      out_data_r.out_bytes  <= merged;
      out_data_r.byte_count <= cnt_inc;
      out_data_r.token_last <= pk_req.last;
      out_data_r.done_res   <= pk_req.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/yay0_lz_decompressor_tb.sv
// Self-checking testbench for yay0_lz_decompressor: literal and copy tokens against a
// behavioral decoder with its own history ring, plus APB writes of the size register.
// Depends on yay0_pkg and the RTL of yay0_lz_decompressor.
`timescale 1ns / 1ps

module yay0_lz_decompressor_tb;
  import yay0_pkg::*;

  localparam logic TOK_LITERAL = 1'b1;
  localparam logic TOK_COPY    = 1'b0;
  localparam logic [CFG_AW-1:0] SIZE_ADDR = {REG_DECODED_SIZE, 2'b00};
  localparam int NUM_DIR      = 15;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT        = 600000;

  typedef struct {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } tok_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Decoder state mirrored by the testbench.
  logic [7:0]        hist [WINDOW_BYTES];
  logic [COUNT_W-1:0] dec_count = '0;
  logic              dec_done = 1'b0;
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;
  out_item_t         decoded_q [$];

  // Directed rows carry a typed expectation alongside the request.
  logic              tab_typed = 1'b0;
  out_item_t         tab_want = '0;

  tok_row_t          dir_rows [NUM_DIR];
  logic              idle_on = 1'b0;
  logic              hold_req = 1'b0;
  int                hold_cnt = 0;
  int                errors = 0;
  int                cycles = 0;

  yay0_lz_decompressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (hist[k]) hist[k] = 8'h00;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %0s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Decodes one token into the byte stream and queues the packed results it yields.
  task automatic decode_token(input in_item_t t);
    logic [8:0]  len;
    logic [12:0] back_dist;
    logic [63:0] acc;
    logic [7:0]  b;
    logic        last;
    int          n;
    if (dec_done) return;
    acc = '0;
    n = 0;
    back_dist = {1'b0, t.link_word[11:0]} + 13'd1;
    if (t.is_literal == TOK_LITERAL) begin
      len = 9'd1;
    end else if (t.link_word[15:CODE_SHIFT] == 4'd0) begin
      len = {1'b0, t.extra_count} + LONG_BIAS;
    end else begin
      len = {5'd0, t.link_word[15:CODE_SHIFT]} + SHORT_BIAS;
    end
    for (int k = 0; k < len; k++) begin
      if (t.is_literal == TOK_LITERAL) b = t.literal_byte;
      else b = hist[12'(dec_count[11:0] - back_dist)];
      hist[dec_count[11:0]] = b;
      dec_count = dec_count + 1'b1;
      acc = acc | ({56'd0, b} << (8 * n));
      n++;
      last = (k + 1 == len);
      if (n == 8 || last) begin
        decoded_q.push_back('{acc, 4'(n), last, dec_count >= {1'b0, size_reg}});
        acc = '0;
        n = 0;
      end
    end
    if (dec_count >= {1'b0, size_reg}) dec_done = 1'b1;
  endtask

  function automatic in_item_t rand_token();
    in_item_t   t;
    logic [3:0] code;
    logic [11:0] d;
    int         r;
    t.literal_byte = 8'($urandom);
    t.extra_count  = 8'($urandom);
    t.link_word    = 16'($urandom);
    if ($urandom_range(99) < 50) begin
      t.is_literal = TOK_LITERAL;
    end else begin
      t.is_literal = TOK_COPY;
      code = ($urandom_range(99) < 15) ? 4'd0 : 4'($urandom_range(1, 15));
      if (code == 4'd0 && $urandom_range(99) < 70) t.extra_count = 8'($urandom_range(0, 15));
      r = $urandom_range(99);
      if (r < 45) d = 12'($urandom_range(0, 15));
      else if (r < 85) d = 12'($urandom_range(0, 511));
      else d = 12'($urandom);
      t.link_word = {code, d};
    end
    return t;
  endfunction

  task automatic send_token(input in_item_t t, input logic typed, input out_item_t want);
    if (idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= t;
    tab_typed <= typed;
    tab_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic reg_write(input logic [SIZE_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SIZE_ADDR;
    cfg_pwdata  <= {8'h00, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    size_reg = val;
  endtask

  task automatic reg_check(input logic [SIZE_W-1:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= SIZE_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {8'h00, want}) report("decoded_size readback", 64'(cfg_prdata), 64'(want));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Lets every pending result drain, then gives dropped tokens time to retire.
  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result acceptor; a pending hold-off keeps ready low for a long stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_on || ($urandom_range(99) >= 34);
      end
    end
  end

  // Prediction happens before the result check so a same-edge result still finds it.
  always @(posedge clk) begin : scoreboard
    int        base;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        base = decoded_q.size();
        decode_token(in_data);
        if (tab_typed) begin
          while (decoded_q.size() > base) void'(decoded_q.pop_back());
          decoded_q.push_back(tab_want);
        end
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report("result with nothing pending", out_data.out_bytes, '0);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_bytes !== want.out_bytes)
            report("out_bytes", out_data.out_bytes, want.out_bytes);
          if (out_data.byte_count !== want.byte_count)
            report("byte_count", 64'(out_data.byte_count), 64'(want.byte_count));
          if (out_data.token_last !== want.token_last)
            report("token_last", 64'(out_data.token_last), 64'(want.token_last));
          if (out_data.done_res !== want.done_res)
            report("done_res", 64'(out_data.done_res), 64'(want.done_res));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("yay0_lz_decompressor verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t t;
    dir_rows = '{
      // A copy reaching back before the first byte reads zero.
      '{'{TOK_COPY,    8'hFF, 16'h1000, 8'hFF}, 1'b1, '{64'h0, 4'd3, 1'b1, 1'b0}},
      '{'{TOK_LITERAL, 8'h00, 16'hFFFF, 8'hFF}, 1'b1, '{64'h00, 4'd1, 1'b1, 1'b0}},
      '{'{TOK_LITERAL, 8'hFF, 16'h0000, 8'h00}, 1'b1, '{64'hFF, 4'd1, 1'b1, 1'b0}},
      '{'{TOK_LITERAL, 8'h5A, 16'hA5C3, 8'h3C}, 1'b1, '{64'h5A, 4'd1, 1'b1, 1'b0}},
      '{'{TOK_COPY,    8'h33, 16'h1000, 8'hC3}, 1'b0, '0},
      '{'{TOK_COPY,    8'h00, 16'hF003, 8'h55}, 1'b0, '0},
      '{'{TOK_COPY,    8'hAA, 16'h0FFF, 8'h00}, 1'b0, '0},
      '{'{TOK_LITERAL, 8'h01, 16'h1234, 8'h99}, 1'b0, '0},
      '{'{TOK_LITERAL, 8'h80, 16'h0000, 8'h00}, 1'b0, '0},
      '{'{TOK_COPY,    8'h11, 16'h0000, 8'hFF}, 1'b0, '0},
      '{'{TOK_COPY,    8'h77, 16'hFFFF, 8'hAA}, 1'b0, '0},
      '{'{TOK_COPY,    8'h00, 16'h2001, 8'h00}, 1'b0, '0},
      '{'{TOK_COPY,    8'hFF, 16'h0007, 8'h01}, 1'b0, '0},
      '{'{TOK_COPY,    8'h00, 16'h7000, 8'hFF}, 1'b0, '0},
      '{'{TOK_COPY,    8'h42, 16'h8010, 8'h7E}, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_check(SIZE_RESET);
    reg_write(24'hFF_FFFF);
    reg_check(24'hFF_FFFF);

    idle_on = 1'b1;
    foreach (dir_rows[k]) send_token(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    repeat (36) send_token(rand_token(), 1'b0, '0);
    settle();

    reg_write(24'(dec_count + 3000 + $urandom_range(0, 4000)));
    idle_on = 1'b0;
    repeat (45) send_token(rand_token(), 1'b0, '0);

    // Long copies between random tokens while the acceptor holds off, so the block backs up into its input.
    hold_req = 1'b1;
    for (int k = 0; k < 8; k++) begin
      t = rand_token();
      if (k % 2 == 0) begin
        t.is_literal = TOK_COPY;
        t.link_word[15:CODE_SHIFT] = 4'd0;
        t.extra_count = 8'hFF;
      end
      send_token(t, 1'b0, '0);
    end
    idle_on = 1'b1;
    settle();

    reg_write(24'(dec_count + 1500));
    repeat (55) send_token(rand_token(), 1'b0, '0);
    settle();

    // This copy runs through the size limit and must still finish in full.
    reg_write(24'(dec_count + 20));
    t = '{TOK_COPY, 8'h00, 16'h0006, 8'd40};
    send_token(t, 1'b0, '0);
    repeat (5) send_token(rand_token(), 1'b0, '0);
    settle();

    // Once done, new size values must not restart decoding.
    reg_write('0);
    reg_check('0);
    repeat (3) send_token(rand_token(), 1'b0, '0);
    settle();
    reg_write(SIZE_RESET);
    repeat (2) send_token(rand_token(), 1'b0, '0);
    settle();

    if (errors == 0) begin
      $display("yay0_lz_decompressor verification clean");
    end else begin
      $display("yay0_lz_decompressor verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/yay0_pkg.sv
rtl/yay0_ring.sv
rtl/yay0_packer.sv
rtl/yay0_lz_decompressor.sv
tb/yay0_lz_decompressor_tb.sv
